FILE: hw/rtl/fdd_pkg.sv
// Shared types and constants for the deauth flood detector.
`timescale 1ns / 1ps

package fdd_pkg;

   // Source table size; the slot index and fill count widths follow from it.
   localparam int SOURCE_SLOTS = 8;
   localparam int SLOT_IDX_W   = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
   localparam int FILL_W       = $clog2(SOURCE_SLOTS + 1);

   // Command queue between front and back; depth must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Frame classification constants.
   localparam logic [15:0] MIN_FRAME_LEN    = 16'd24;
   localparam logic [1:0]  FTYPE_MGMT       = 2'd0;
   localparam logic [3:0]  SUBTYPE_DEAUTH   = 4'd12;
   localparam logic [3:0]  SUBTYPE_DISASSOC = 4'd10;

   // Item function codes.
   localparam logic FUNC_FRAME = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // Register map.
   localparam int                    CSR_INDEX_W        = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALERT_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH   = 8'd1;
   localparam logic [15:0]            THRESHOLD_RESET     = 16'd10;
   localparam logic [31:0]            WINDOW_RESET        = 32'd1000;

   typedef struct packed {
      logic              func;
      logic [15:0]       frame_control;
      logic [15:0]       frame_length;
      logic [47:0]       source_mac;
      logic [47:0]       bssid_mac;
      logic signed [7:0] signal_rssi;
      logic [7:0]        radio_channel;
      logic [31:0]       now_ms;
   } req_data_type;

   typedef struct packed {
      logic              alert_valid;
      logic [31:0]       alert_sequence;
      logic [47:0]       alert_source;
      logic [47:0]       alert_bssid;
      logic signed [7:0] alert_rssi;
      logic [7:0]        alert_channel;
      logic              alert_is_deauth;
      logic [15:0]       window_count;
      logic [31:0]       deauth_total;
      logic [31:0]       disassoc_total;
   } rsp_data_type;

   typedef enum logic [1:0] {
      OP_IGNORE   = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_DEAUTH   = 2'd2,
      OP_DISASSOC = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [47:0]       source_mac;
      logic [47:0]       bssid_mac;
      logic signed [7:0] signal_rssi;
      logic [7:0]        radio_channel;
      logic [31:0]       now_ms;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_xfer_type;

   typedef struct packed {
      logic [15:0] alert_threshold;
      logic [31:0] window_length_ms;
   } cfg_type;

endpackage

FILE: hw/rtl/fdd_front.sv
// Front end: takes request transactions and classifies them into commands.
`timescale 1ns / 1ps

module fdd_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fdd_pkg::req_data_type req_data,
   input  logic                  queue_full,
   output fdd_pkg::cmd_xfer_type push
);
   import fdd_pkg::*;

   logic [1:0] ftype;
   logic [3:0] subtype;
   logic       mgmt_ok;
   op_type     op;

   assign ftype   = req_data.frame_control[3:2];
   assign subtype = req_data.frame_control[7:4];
   assign mgmt_ok = (req_data.frame_length >= MIN_FRAME_LEN) && (ftype == FTYPE_MGMT);

   always_comb begin
      op = OP_IGNORE;
      if (req_data.func == FUNC_CLEAR) begin
         op = OP_CLEAR;
      end else if (mgmt_ok && subtype == SUBTYPE_DEAUTH) begin
         op = OP_DEAUTH;
      end else if (mgmt_ok && subtype == SUBTYPE_DISASSOC) begin
         op = OP_DISASSOC;
      end
   end

   assign req_stall = queue_full;

   always_comb begin
      push.valid              = req_valid && !queue_full;
      push.cmd.op             = op;
      push.cmd.source_mac     = req_data.source_mac;
      push.cmd.bssid_mac      = req_data.bssid_mac;
      push.cmd.signal_rssi    = req_data.signal_rssi;
      push.cmd.radio_channel  = req_data.radio_channel;
      push.cmd.now_ms         = req_data.now_ms;
   end

endmodule

FILE: hw/rtl/fdd_queue.sv
// Short command queue that decouples the front end from the table sequencer.
`timescale 1ns / 1ps

module fdd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  fdd_pkg::cmd_xfer_type push,
   input  logic                  pop,
   output fdd_pkg::cmd_xfer_type head,
   output logic                  full
);
   import fdd_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

FILE: hw/rtl/fdd_back.sv
// Back end: source table sequencer, counters and result register.
`timescale 1ns / 1ps

module fdd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  fdd_pkg::cfg_type      cfg,
   input  fdd_pkg::cmd_xfer_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fdd_pkg::rsp_data_type rsp_data
);
   import fdd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MATCH = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_WIN   = 6'b001000,
      ST_CNT   = 6'b010000,
      ST_EMIT  = 6'b100000
   } back_state_type;

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [SLOT_IDX_W-1:0] cur_ff, cur_in;
   logic [SLOT_IDX_W-1:0] pick_ff, pick_in;
   logic [31:0]           pick_start_ff, pick_start_in;
   logic                  fresh_ff, fresh_in;
   logic                  expired_ff, expired_in;
   logic [31:0]           alert_cnt_ff, alert_cnt_in;
   logic [31:0]           deauth_ff, deauth_in;
   logic [31:0]           disassoc_ff, disassoc_in;
   rsp_data_type          res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   logic [47:0]           slot_source_ff [SOURCE_SLOTS];
   logic [47:0]           slot_source_in [SOURCE_SLOTS];
   logic [31:0]           slot_start_ff  [SOURCE_SLOTS];
   logic [31:0]           slot_start_in  [SOURCE_SLOTS];
   logic [15:0]           slot_count_ff  [SOURCE_SLOTS];
   logic [15:0]           slot_count_in  [SOURCE_SLOTS];

   logic [SOURCE_SLOTS-1:0] hit_vec;
   logic                    hit_any;
   logic [SLOT_IDX_W-1:0]   hit_idx;
   logic [31:0]             cur_start;
   logic [15:0]             cur_count;
   logic                    scan_take;
   logic [SLOT_IDX_W-1:0]   scan_pick;
   logic [31:0]             start_eff;
   logic [31:0]             elapsed;
   logic [15:0]             new_count;
   logic                    out_free;

   // Active slots always form a prefix of the table, so the fill count marks them.
   always_comb begin
      for (int i = 0; i < SOURCE_SLOTS; i++) begin
         hit_vec[i] = (FILL_W'(i) < fill_ff) && (slot_source_ff[i] == cmd_ff.source_mac);
      end
   end

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = SOURCE_SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_IDX_W'(i);
         end
      end
   end

   assign cur_start = slot_start_ff[cur_ff];
   assign cur_count = slot_count_ff[cur_ff];
   // Strict compare keeps the lowest index on equal start times.
   assign scan_take = (cur_ff == '0) || (cur_start < pick_start_ff);
   assign scan_pick = scan_take ? cur_ff : pick_ff;
   assign start_eff = fresh_ff ? cmd_ff.now_ms : cur_start;
   assign elapsed   = cmd_ff.now_ms - start_eff;
   assign new_count = ((fresh_ff || expired_ff) ? 16'd0 : cur_count) + 16'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      pick_in       = pick_ff;
      pick_start_in = pick_start_ff;
      fresh_in      = fresh_ff;
      expired_in    = expired_ff;
      alert_cnt_in  = alert_cnt_ff;
      deauth_in     = deauth_ff;
      disassoc_in   = disassoc_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      slot_source_in = slot_source_ff;
      slot_start_in  = slot_start_ff;
      slot_count_in  = slot_count_ff;
      pop           = 1'b0;

      // Drop the result once the receiver has taken it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cmd_in   = head.cmd;
               res_in   = '0;
               fresh_in = 1'b0;
               case (head.cmd.op)
                  OP_CLEAR: begin
                     fill_in      = '0;
                     alert_cnt_in = '0;
                     state_in     = ST_EMIT;
                  end
                  OP_DEAUTH: begin
                     deauth_in = deauth_ff + 32'd1;
                     state_in  = ST_MATCH;
                  end
                  OP_DISASSOC: begin
                     disassoc_in = disassoc_ff + 32'd1;
                     state_in    = ST_MATCH;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_MATCH: begin
            if (hit_any) begin
               cur_in   = hit_idx;
               state_in = ST_WIN;
            end else if (fill_ff < FILL_W'(SOURCE_SLOTS)) begin
               cur_in   = fill_ff[SLOT_IDX_W-1:0];
               fill_in  = fill_ff + 1'b1;
               fresh_in = 1'b1;
               state_in = ST_WIN;
            end else begin
               cur_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Walk the full table once for the oldest window start.
            pick_in       = scan_pick;
            pick_start_in = scan_take ? cur_start : pick_start_ff;
            if (cur_ff == SLOT_IDX_W'(SOURCE_SLOTS - 1)) begin
               cur_in   = scan_pick;
               fresh_in = 1'b1;
               state_in = ST_WIN;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         ST_WIN: begin
            expired_in = (elapsed >= cfg.window_length_ms);
            state_in   = ST_CNT;
         end
         ST_CNT: begin
            slot_count_in[cur_ff] = new_count;
            if (fresh_ff) begin
               slot_source_in[cur_ff] = cmd_ff.source_mac;
            end
            if (fresh_ff || expired_ff) begin
               slot_start_in[cur_ff] = cmd_ff.now_ms;
            end
            res_in.window_count = new_count;
            if (new_count == cfg.alert_threshold) begin
               alert_cnt_in           = alert_cnt_ff + 32'd1;
               res_in.alert_valid     = 1'b1;
               res_in.alert_sequence  = alert_cnt_ff + 32'd1;
               res_in.alert_source    = cmd_ff.source_mac;
               res_in.alert_bssid     = cmd_ff.bssid_mac;
               res_in.alert_rssi      = cmd_ff.signal_rssi;
               res_in.alert_channel   = cmd_ff.radio_channel;
               res_in.alert_is_deauth = (cmd_ff.op == OP_DEAUTH);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold here until the output register is free.
            if (out_free) begin
               rsp_data_in                = res_ff;
               rsp_data_in.deauth_total   = deauth_ff;
               rsp_data_in.disassoc_total = disassoc_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         alert_cnt_ff <= '0;
         deauth_ff    <= '0;
         disassoc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         alert_cnt_ff <= alert_cnt_in;
         deauth_ff    <= deauth_in;
         disassoc_ff  <= disassoc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      cur_ff         <= cur_in;
      pick_ff        <= pick_in;
      pick_start_ff  <= pick_start_in;
      fresh_ff       <= fresh_in;
      expired_ff     <= expired_in;
      res_ff         <= res_in;
      rsp_data_ff    <= rsp_data_in;
      slot_source_ff <= slot_source_in;
      slot_start_ff  <= slot_start_in;
      slot_count_ff  <= slot_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/deauth_flood_detector_core.sv
// Top level of the deauth flood detector: register file, front, queue and back.
`timescale 1ns / 1ps

// Usage:
//   req_*  : one transaction per received frame or clear command (func = 1).
//            Taken when req_valid is high and req_stall is low; req_stall rises
//            only while the two-entry command queue is full.
//   rsp_*  : exactly one result transaction per request, in request order,
//            held in an output register until rsp_stall is low.
//   csr_*  : register writes (index 0 alert threshold, 1 window length in ms),
//            always ready; write only while no request is outstanding.
// Timing: a request lands in the queue at the accepting edge. The sequencer
//   then passes a clear or an ignored frame from idle straight to emit, and a
//   counted deauth/disassoc frame through match, window check, count and emit;
//   when the source is new and the table is full, a scan of all SOURCE_SLOTS
//   slots (8) for the oldest window start comes between match and window check.
//   The table sequencer serves one command at a time.
// Reset: synchronous; empties the table and zeroes all totals, restores the
//   register defaults (threshold 10, window 1000 ms).
// A stalled result holds the sequencer; the queue takes requests until full.

module deauth_flood_detector_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  fdd_pkg::req_data_type                     req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output fdd_pkg::rsp_data_type                     rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [fdd_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [31:0]                               csr_wdata
);
   import fdd_pkg::*;

   logic [15:0]  thr_ff, thr_in;
   logic [31:0]  win_ff, win_in;
   cfg_type      cfg;
   cmd_xfer_type push;
   cmd_xfer_type head;
   logic         queue_full;
   logic         pop;

   assign csr_ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      win_in = win_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ALERT_THRESHOLD) begin
            thr_in = csr_wdata[15:0];
         end else if (csr_index == CSR_WINDOW_LENGTH) begin
            win_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         win_ff <= WINDOW_RESET;
      end else begin
         thr_ff <= thr_in;
         win_ff <= win_in;
      end
   end

   assign cfg.alert_threshold  = thr_ff;
   assign cfg.window_length_ms = win_ff;

   fdd_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   fdd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   fdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An alert fires only when the window count reaches the threshold.
   a_alert_at_threshold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.alert_valid) |-> (rsp_data.window_count == thr_ff))
      else $error("alert raised with window count off the threshold");

   // Without an alert, the alert fields stay zero.
   a_quiet_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.alert_valid) |->
         (rsp_data.alert_sequence == '0 && rsp_data.alert_source == '0 &&
          rsp_data.alert_bssid == '0 && rsp_data.alert_is_deauth == 1'b0))
      else $error("alert fields set on a result without an alert");

   // A full queue must hold off the requester on the very same cycle.
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (queue_full && req_valid) |-> !push.valid)
      else $error("command pushed into a full queue");

endmodule
